FILE: rtl/core/jpd_pkg.sv
// Shared constants, types and beat layout for the joint packet deframer.
package jpd_pkg;

    localparam int MAX_JOINTS  = 7;
    localparam int PKT_HEADER  = 16;
    localparam int STORE_BYTES = PKT_HEADER + 16 * MAX_JOINTS;
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);
    localparam int HDR_AW      = $clog2(PKT_HEADER);
    localparam int DATA_WORDS  = 4 * MAX_JOINTS;
    localparam int WORD_AW     = $clog2(DATA_WORDS);
    localparam int RAM_AW      = WORD_AW + 1;
    localparam int RAM_DEPTH   = 2 ** RAM_AW;
    localparam int JW          = $clog2(MAX_JOINTS + 1);
    localparam int TOT_W       = $clog2(DATA_WORDS + 1);
    localparam int TDATA_W     = 120;

    localparam logic [31:0] PKT_MAGIC   = 32'h4F58_4544;
    localparam logic [7:0]  PKT_VERSION = 8'd1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_JOINT  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_COUNT   = 3'd4,
        ST_SIZE    = 3'd5
    } status_t;

    typedef struct packed {
        status_t         status;
        logic            vel;
        logic [JW-1:0]   nl;
        logic [JW-1:0]   nr;
        logic [63:0]     ts;
        logic            bank;
    } job_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [2:0]  joint_index;
        logic        quantity;
        logic        arm_select;
        logic [7:0]  sender_id;
        logic [63:0] device_time;
        logic [2:0]  right_count;
        logic [2:0]  left_count;
        logic        has_velocity;
        logic [2:0]  status_code;
    } out_beat_t;

endpackage

FILE: rtl/core/jpd_ram.sv
// Generic simple dual-port RAM with registered read.
module jpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/jpd_front.sv
// Front end: byte intake, header capture, word packing and packet checks.
module jpd_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,
    input  logic                    s_tlast,
    output logic                    ram_wr_en,
    output logic [jpd_pkg::RAM_AW-1:0] ram_wr_addr,
    output logic [31:0]             ram_wr_data,
    output logic                    job_push,
    output jpd_pkg::job_t           job_data,
    input  jpd_pkg::bank_rel_t      bank_rel
);
    import jpd_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovr_reg, ovr_next;
    logic             pend_reg, pend_next;
    logic             wr_bank_reg, wr_bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [7:0]       hdr_reg [PKT_HEADER];
    logic [23:0]      wbuf_reg;

    logic             accept;
    logic             has_room;
    logic [CNT_W-1:0] rel_cnt;
    logic [31:0]      magic;
    logic [8:0]       joint_sum;
    logic [12:0]      expected;
    status_t          status;

    assign s_tready = !pend_reg && !busy_reg[wr_bank_reg];
    assign accept   = s_tvalid && s_tready;
    assign has_room = cnt_reg < CNT_W'(STORE_BYTES);
    assign rel_cnt  = cnt_reg - CNT_W'(PKT_HEADER);

    assign ram_wr_en   = accept && has_room && (cnt_reg >= CNT_W'(PKT_HEADER))
                         && (cnt_reg[1:0] == 2'd3);
    assign ram_wr_addr = {wr_bank_reg, rel_cnt[WORD_AW+1:2]};
    assign ram_wr_data = {s_tdata, wbuf_reg};

    assign magic     = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign joint_sum = {1'b0, hdr_reg[6]} + {1'b0, hdr_reg[7]};
    assign expected  = 13'(PKT_HEADER)
                       + ((hdr_reg[5] != 8'd0) ? {1'b0, joint_sum, 3'b000}
                                               : {2'b00, joint_sum, 2'b00});

    always_comb begin
        if (cnt_reg < CNT_W'(PKT_HEADER)) begin
            status = ST_SHORT;
        end else if (magic != PKT_MAGIC) begin
            status = ST_MAGIC;
        end else if (hdr_reg[4] != PKT_VERSION) begin
            status = ST_VERSION;
        end else if ((hdr_reg[6] > 8'(MAX_JOINTS)) || (hdr_reg[7] > 8'(MAX_JOINTS))) begin
            status = ST_COUNT;
        end else if (ovr_reg || (13'(cnt_reg) != expected)) begin
            status = ST_SIZE;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        job_push      = pend_reg;
        job_data      = '0;
        job_data.status = status;
        job_data.bank = wr_bank_reg;
        if (status == ST_OK) begin
            job_data.vel = hdr_reg[5] != 8'd0;
            job_data.nl  = JW'(hdr_reg[6]);
            job_data.nr  = JW'(hdr_reg[7]);
            job_data.ts  = {hdr_reg[15], hdr_reg[14], hdr_reg[13], hdr_reg[12],
                            hdr_reg[11], hdr_reg[10], hdr_reg[9], hdr_reg[8]};
        end
    end

    always_comb begin
        cnt_next     = cnt_reg;
        ovr_next     = ovr_reg;
        pend_next    = pend_reg;
        wr_bank_next = wr_bank_reg;
        busy_next    = busy_reg;
        if (bank_rel.valid) begin
            busy_next[bank_rel.bank] = 1'b0;
        end
        if (accept) begin
            if (has_room) begin
                cnt_next = cnt_reg + 1'b1;
            end else begin
                ovr_next = 1'b1;
            end
            if (s_tlast) begin
                pend_next = 1'b1;
            end
        end
        if (pend_reg) begin
            busy_next[wr_bank_reg] = 1'b1;
            wr_bank_next           = !wr_bank_reg;
            cnt_next               = '0;
            ovr_next               = 1'b0;
            pend_next              = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            ovr_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            wr_bank_reg <= 1'b0;
            busy_reg    <= '0;
        end else begin
            cnt_reg     <= cnt_next;
            ovr_reg     <= ovr_next;
            pend_reg    <= pend_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && has_room) begin
            wbuf_reg <= {s_tdata, wbuf_reg[23:8]};
            if (cnt_reg < CNT_W'(PKT_HEADER)) begin
                hdr_reg[cnt_reg[HDR_AW-1:0]] <= s_tdata;
            end
        end
    end

endmodule

FILE: rtl/core/jpd_queue.sv
// Two-entry job queue between the front end and the back end.
module jpd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jpd_pkg::job_t push_data,
    input  logic          pop,
    output jpd_pkg::job_t pop_data,
    output logic          empty
);
    import jpd_pkg::*;

    job_t       q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign empty    = count_reg == 2'd0;
    assign pop_data = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/jpd_back.sv
// Back end: status beat and joint word sequencing into the output register.
module jpd_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [7:0]                 source_tag,
    input  logic                       q_empty,
    input  jpd_pkg::job_t              q_data,
    output logic                       q_pop,
    output logic                       ram_rd_en,
    output logic [jpd_pkg::RAM_AW-1:0] ram_rd_addr,
    input  logic [31:0]                ram_rd_data,
    output jpd_pkg::bank_rel_t         bank_rel,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic                       m_tuser,
    output logic                       m_tlast,
    output jpd_pkg::out_beat_t         m_beat
);
    import jpd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STAT = 4'b0010,
        S_READ = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    job_t               job_reg;
    logic               arm_reg, q_reg;
    logic [JW-1:0]      idx_reg;
    logic [WORD_AW-1:0] off_reg;
    logic [TOT_W-1:0]   remain_reg;
    logic               valid_reg, valid_next;
    logic               kind_reg, last_reg;
    out_beat_t          beat_reg, beat_next;

    logic               out_free;
    logic               stat_last;
    logic [TOT_W-1:0]   total;
    logic [JW-1:0]      arm_cnt;
    logic               load_stat, load_val;

    assign out_free  = !valid_reg || m_tready;
    assign total     = TOT_W'(({2'b00, job_reg.nl} + {2'b00, job_reg.nr}) << job_reg.vel);
    assign stat_last = (job_reg.status != ST_OK) || (total == '0);
    assign arm_cnt   = arm_reg ? job_reg.nr : job_reg.nl;
    assign load_stat = (state_reg == S_STAT) && out_free;
    assign load_val  = (state_reg == S_WAIT) && out_free;

    assign q_pop       = (state_reg == S_IDLE) && !q_empty;
    assign ram_rd_en   = state_reg == S_READ;
    assign ram_rd_addr = {job_reg.bank, off_reg};

    assign bank_rel.valid = (load_stat && stat_last) || (load_val && remain_reg == TOT_W'(1));
    assign bank_rel.bank  = job_reg.bank;

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_beat   = beat_reg;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    state_next = S_STAT;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    state_next = stat_last ? S_IDLE : S_READ;
                end
            end
            S_READ: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    state_next = (remain_reg == TOT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        beat_next = beat_reg;
        if (load_stat) begin
            beat_next              = '0;
            beat_next.status_code  = job_reg.status;
            beat_next.has_velocity = job_reg.vel;
            beat_next.left_count   = 3'(job_reg.nl);
            beat_next.right_count  = 3'(job_reg.nr);
            beat_next.device_time  = job_reg.ts;
            beat_next.sender_id    = source_tag;
        end else if (load_val) begin
            beat_next             = '0;
            beat_next.arm_select  = arm_reg;
            beat_next.quantity    = q_reg;
            beat_next.joint_index = 3'(idx_reg);
            beat_next.value_bits  = ram_rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
        if (q_pop) begin
            job_reg <= q_data;
        end
        if (load_stat) begin
            kind_reg   <= KIND_STATUS;
            last_reg   <= stat_last;
            remain_reg <= total;
            arm_reg    <= job_reg.nl == '0;
            q_reg      <= 1'b0;
            idx_reg    <= '0;
            off_reg    <= '0;
        end
        if (load_val) begin
            kind_reg   <= KIND_JOINT;
            last_reg   <= remain_reg == TOT_W'(1);
            remain_reg <= remain_reg - 1'b1;
            off_reg    <= off_reg + 1'b1;
            if (idx_reg == arm_cnt - 1'b1) begin
                idx_reg <= '0;
                if (!q_reg && job_reg.vel) begin
                    q_reg <= 1'b1;
                end else begin
                    q_reg   <= 1'b0;
                    arm_reg <= 1'b1;
                end
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/joint_packet_deframer.sv
// Joint packet deframer top level: stream ports, source tag register and assertions.
//
// Bytes of one datagram enter on the s_ channel, one per beat, with s_tlast on
// the final byte. The front end stores the bytes and, in the cycle after the
// final byte, checks the packet and queues a job; s_tready is low in that
// cycle. Two packet buffers alternate, so the next datagram streams in while
// the back end still drains the previous one. Apart from that cycle, input
// stalls only when both buffers hold packets whose final beat is not yet loaded.
// Each datagram gives one status beat (m_tuser low) and, for a good packet,
// one beat per joint word (m_tuser high); m_tlast marks the final beat.
// The status beat passes through the job queue and the back end's job
// register and S_STAT state; each joint word then passes through S_READ for
// the buffer read and S_WAIT to load the output register. The output register
// holds its beat while m_tready is low; the back end waits without losing anything.
// The source tag is written on the cfg_ channel, which is always ready, and
// resets to zero. Reset clears all control state and empties both buffers.
module joint_packet_deframer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // data_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status_code, has_velocity, left_count, right_count, device_time, sender_id,
    // arm_select, quantity, joint_index, value_bits, one zero pad bit
    output logic [jpd_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tuser,   // item_kind
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [7:0]                  cfg_data
);
    import jpd_pkg::*;

    logic [7:0]        source_tag_reg;
    logic              ram_wr_en;
    logic [RAM_AW-1:0] ram_wr_addr;
    logic [31:0]       ram_wr_data;
    logic              ram_rd_en;
    logic [RAM_AW-1:0] ram_rd_addr;
    logic [31:0]       ram_rd_data;
    logic              job_push;
    job_t              job_data;
    logic              q_pop;
    job_t              q_data;
    logic              q_empty;
    bank_rel_t         bank_rel;
    out_beat_t         m_beat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_tag_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            source_tag_reg <= cfg_data;
        end
    end

    assign m_tdata = {1'b0, m_beat};

    jpd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .job_push    (job_push),
        .job_data    (job_data),
        .bank_rel    (bank_rel)
    );

    jpd_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    jpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    jpd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .source_tag  (source_tag_reg),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .bank_rel    (bank_rel),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .m_beat      (m_beat)
    );

`ifndef SYNTHESIS
    a_fail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_STATUS && m_beat.status_code != ST_OK) |-> m_tlast)
        else $error("failed packet status beat without last flag");

    a_joint_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_JOINT) |-> (m_tdata[81:0] == '0))
        else $error("joint beat carries status fields");

    a_check_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input accepted during packet check");

    a_single_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_push) |=> !job_push)
        else $error("two jobs pushed in consecutive cycles");
`endif

endmodule
